### sv/utf8_stream_detector_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 stream detector assertion macros
// Shared property wrappers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DETECTOR_DEFINES_SVH
`define UTF8_STREAM_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream detector package
// Decoder modes, status codes, count types and register map shared by the
// detector modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned COUNT_WIDTH  = 32;
	localparam int unsigned THRESH_WIDTH = 32;
	localparam int unsigned CMP_WIDTH    = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH
	                                                                    : THRESH_WIDTH;
	localparam int unsigned FIELD_WIDTH  = 32;

	typedef logic [COUNT_WIDTH-1:0]  count_t;
	typedef logic [THRESH_WIDTH-1:0] thresh_t;
	typedef logic [CMP_WIDTH-1:0]    cmp_t;
	typedef logic [FIELD_WIDTH-1:0]  field_t;

	localparam thresh_t THRESH_RESET = thresh_t'(100);

	// Decoder mode: the NEED modes count continuation bytes still due.
	typedef enum logic [2:0] {
		MODE_WAIT    = 3'd0,
		MODE_CLOSED  = 3'd1,
		MODE_REFUSED = 3'd2,
		MODE_NEED1   = 3'd3,
		MODE_NEED2   = 3'd4,
		MODE_NEED3   = 3'd5,
		MODE_NEED4   = 3'd6,
		MODE_NEED5   = 3'd7
	} mode_t;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_IDLE    = 2'd0;
	localparam status_t STATUS_INSEQ   = 2'd1;
	localparam status_t STATUS_REFUSED = 2'd2;

	// Register map: one register, at byte address zero.
	localparam int unsigned ADDR_WIDTH = 3;
	localparam logic REG_THRESHOLD = 1'b0;

	// Outcome of one byte, passed from the decoder to the top level.
	typedef struct packed {
		mode_t next_mode;
		logic  char_done;
		logic  multi_done;
	} step_t;

endpackage

### sv/utf8d_step.sv
// ----------------------------------------------------------------------------
// UTF-8 stream detector byte decoder
// Works out the next decoder mode for one byte and whether a character
// (and a multibyte character) completes with it.
// ----------------------------------------------------------------------------
module utf8d_step (
	input  utf8d_pkg::mode_t mode,
	input  logic [7:0]       data_byte,
	output utf8d_pkg::step_t step
);

	utf8d_pkg::mode_t lead_mode;
	logic             lead_ascii;
	logic             is_cont;

	assign is_cont = (data_byte[7:6] == 2'b10);

	// Lead byte classes, including the original five and six byte forms.
	always_comb begin
		lead_mode  = utf8d_pkg::MODE_REFUSED;
		lead_ascii = 1'b0;
		priority if (data_byte == 8'h00) begin
			lead_mode = utf8d_pkg::MODE_CLOSED;
		end else if (data_byte[7] == 1'b0) begin
			lead_mode  = utf8d_pkg::MODE_WAIT;
			lead_ascii = 1'b1;
		end else if (data_byte[7:5] == 3'b110) begin
			lead_mode = utf8d_pkg::MODE_NEED1;
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_mode = utf8d_pkg::MODE_NEED2;
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_mode = utf8d_pkg::MODE_NEED3;
		end else if (data_byte[7:2] == 6'b111110) begin
			lead_mode = utf8d_pkg::MODE_NEED4;
		end else if (data_byte[7:1] == 7'b1111110) begin
			lead_mode = utf8d_pkg::MODE_NEED5;
		end else begin
			lead_mode = utf8d_pkg::MODE_REFUSED;
		end
	end

	always_comb begin
		step.next_mode  = utf8d_pkg::MODE_REFUSED;
		step.char_done  = 1'b0;
		step.multi_done = 1'b0;
		unique case (mode)
			utf8d_pkg::MODE_WAIT: begin
				step.next_mode = lead_mode;
				step.char_done = lead_ascii;
			end
			utf8d_pkg::MODE_CLOSED,
			utf8d_pkg::MODE_REFUSED: begin
				step.next_mode = utf8d_pkg::MODE_REFUSED;
			end
			utf8d_pkg::MODE_NEED1: begin
				if (is_cont) begin
					step.next_mode  = utf8d_pkg::MODE_WAIT;
					step.char_done  = 1'b1;
					step.multi_done = 1'b1;
				end
			end
			utf8d_pkg::MODE_NEED2,
			utf8d_pkg::MODE_NEED3,
			utf8d_pkg::MODE_NEED4,
			utf8d_pkg::MODE_NEED5: begin
				if (is_cont) begin
					step.next_mode = utf8d_pkg::mode_t'(mode - 3'd1);
				end
			end
			default: begin
				step.next_mode = utf8d_pkg::MODE_REFUSED;
			end
		endcase
	end

endmodule

### sv/utf8_stream_detector.sv
// ----------------------------------------------------------------------------
// UTF-8 stream detector
// Checks a byte stream against UTF-8 lead and continuation rules, counts
// accepted characters and reports a result for every byte.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  byte      byte_valid, byte_ready, data_byte         in
//  result    result_valid, result_ready, byte_ok,      out
//            detect_status, char_count,
//            multibyte_count, confident
//  config    psel, penable, pwrite, paddr, pwdata,     in / prdata, pready out
//            prdata, pready
//
// One byte per cycle while results are taken: each request is decoded in the
// cycle it is accepted, and its registered result appears in the next cycle.
// The result register frees as it is taken, so byte_ready is high whenever the
// result slot is empty or being read out in the same cycle.
// Reset returns the decoder to waiting for a lead byte, clears both counts and
// sets the threshold to 100.
// ----------------------------------------------------------------------------
`include "utf8_stream_detector_defines.svh"

module utf8_stream_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   byte_valid,
	output logic                                   byte_ready,
	input  logic [7:0]                             data_byte,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic                                   byte_ok,
	output logic [1:0]                             detect_status,
	output logic [31:0]                            char_count,
	output logic [31:0]                            multibyte_count,
	output logic                                   confident,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [utf8d_pkg::ADDR_WIDTH-1:0]       paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	utf8d_pkg::mode_t   mode_q;
	utf8d_pkg::count_t  char_q;
	utf8d_pkg::count_t  multi_q;
	utf8d_pkg::thresh_t thresh_q;
	utf8d_pkg::step_t   step;
	utf8d_pkg::count_t  char_next;
	utf8d_pkg::count_t  multi_next;
	utf8d_pkg::status_t status_next;
	logic               conf_next;
	logic               byte_take;
	logic               cfg_write;

	logic               valid_q;
	logic               ok_q;
	utf8d_pkg::status_t status_q;
	utf8d_pkg::field_t  char_out_q;
	utf8d_pkg::field_t  multi_out_q;
	logic               conf_q;

	utf8d_step u_step (
		.mode      (mode_q),
		.data_byte (data_byte),
		.step      (step)
	);

	assign byte_ready = !valid_q || result_ready;
	assign byte_take  = byte_valid && byte_ready;

	// Saturating counts.
	always_comb begin
		char_next  = char_q;
		multi_next = multi_q;
		if (step.char_done && (char_q != '1)) begin
			char_next = char_q + utf8d_pkg::count_t'(1);
		end
		if (step.multi_done && (multi_q != '1)) begin
			multi_next = multi_q + utf8d_pkg::count_t'(1);
		end
	end

	// Status from the mode the byte leaves behind.
	always_comb begin
		unique case (step.next_mode)
			utf8d_pkg::MODE_REFUSED: status_next = utf8d_pkg::STATUS_REFUSED;
			utf8d_pkg::MODE_WAIT,
			utf8d_pkg::MODE_CLOSED:  status_next = utf8d_pkg::STATUS_IDLE;
			default:                 status_next = utf8d_pkg::STATUS_INSEQ;
		endcase
	end

	assign conf_next = utf8d_pkg::cmp_t'(multi_next) > utf8d_pkg::cmp_t'(thresh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= utf8d_pkg::MODE_WAIT;
			char_q  <= '0;
			multi_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (byte_take) begin
				mode_q  <= step.next_mode;
				char_q  <= char_next;
				multi_q <= multi_next;
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			ok_q        <= (step.next_mode != utf8d_pkg::MODE_REFUSED);
			status_q    <= status_next;
			char_out_q  <= utf8d_pkg::field_t'(char_next);
			multi_out_q <= utf8d_pkg::field_t'(multi_next);
			conf_q      <= conf_next;
		end
	end

	assign result_valid    = valid_q;
	assign byte_ok         = ok_q;
	assign detect_status   = status_q;
	assign char_count      = char_out_q;
	assign multibyte_count = multi_out_q;
	assign confident       = conf_q;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= utf8d_pkg::THRESH_RESET;
		end else if (cfg_write && (paddr[2] == utf8d_pkg::REG_THRESHOLD)) begin
			thresh_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == utf8d_pkg::REG_THRESHOLD) ? thresh_q : '0;

	`UTF8D_ASSERT_NEXT(a_refused_sticky, mode_q == utf8d_pkg::MODE_REFUSED, mode_q == utf8d_pkg::MODE_REFUSED, "refused state was left")
	`UTF8D_ASSERT_NOW(a_multi_le_char, 1'b1, multi_q <= char_q, "multibyte count exceeds character count")
	`UTF8D_ASSERT_NEXT(a_counts_hold, !byte_take, $stable(char_q) && $stable(multi_q), "counts moved without a request")
	`UTF8D_ASSERT_NOW(a_ok_matches_status, valid_q, ok_q == (status_q != utf8d_pkg::STATUS_REFUSED), "byte_ok disagrees with status")

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream detector testbench
// Feeds directed and random byte streams through the detector under four
// pacing regimes and several threshold settings. Each result is checked against
// hand-worked values or an in-bench decoder that tracks mode, counts and threshold.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PHASE_BYTES  = 180;
	localparam logic [utf8d_pkg::ADDR_WIDTH-1:0] THRESH_ADDR =
		utf8d_pkg::ADDR_WIDTH'(4 * utf8d_pkg::REG_THRESHOLD);

	typedef struct packed {
		logic               ok;
		utf8d_pkg::status_t status;
		utf8d_pkg::field_t  chars;
		utf8d_pkg::field_t  multi;
		logic               confident;
	} report_t;

	typedef struct packed {
		logic [7:0] data;
		logic       known;
		report_t    want;
	} directed_row_t;

	typedef enum logic [1:0] {
		END_STRAY_CONT,
		END_BAD_LEAD,
		END_TRUNCATED,
		END_AFTER_NUL
	} ending_t;

	// The first four rows are worked out by hand from the reset state.
	localparam directed_row_t DIRECTED_ROWS [24] = '{
		'{8'h01, 1'b1, '{1'b1, utf8d_pkg::STATUS_IDLE,  32'd1, 32'd0, 1'b0}},
		'{8'h7F, 1'b1, '{1'b1, utf8d_pkg::STATUS_IDLE,  32'd2, 32'd0, 1'b0}},
		'{8'hC0, 1'b1, '{1'b1, utf8d_pkg::STATUS_INSEQ, 32'd2, 32'd0, 1'b0}},
		'{8'hBF, 1'b1, '{1'b1, utf8d_pkg::STATUS_IDLE,  32'd3, 32'd1, 1'b0}},
		'{8'hDF, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'hE0, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'hBF, 1'b0, '0},
		'{8'hF7, 1'b0, '0}, '{8'hBF, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'hF8, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'hBF, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'hFD, 1'b0, '0}, '{8'hBF, 1'b0, '0}, '{8'hBF, 1'b0, '0}, '{8'hBF, 1'b0, '0},
		'{8'hBF, 1'b0, '0}, '{8'h80, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        byte_valid    = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte     = 8'h00;
	logic        result_valid;
	logic        result_ready  = 1'b0;
	logic        byte_ok;
	logic [1:0]  detect_status;
	logic [31:0] char_count;
	logic [31:0] multibyte_count;
	logic        confident;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [utf8d_pkg::ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	// Decoder state mirrored in the bench.
	utf8d_pkg::mode_t   dec_mode;
	logic               dec_in_multi;
	utf8d_pkg::count_t  dec_chars;
	utf8d_pkg::count_t  dec_multi;
	utf8d_pkg::thresh_t dec_thresh;

	report_t awaited_reports [$];
	report_t oldest_report;
	int      send_idle_pct   = 0;
	int      ready_stall_pct = 0;
	int      bytes_sent      = 0;
	int      reports_checked = 0;
	int      fail_count      = 0;
	int      quiet_cycles    = 0;
	ending_t ending;

	utf8_stream_detector DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_ready      (byte_ready),
		.data_byte       (data_byte),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.byte_ok         (byte_ok),
		.detect_status   (detect_status),
		.char_count      (char_count),
		.multibyte_count (multibyte_count),
		.confident       (confident),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic utf8d_pkg::count_t sat_inc(input utf8d_pkg::count_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Advances the mirrored decoder by one byte and returns the report it should give.
	function automatic report_t decode_next(input logic [7:0] b);
		report_t          r;
		utf8d_pkg::mode_t nxt;
		logic             done;
		done = 1'b0;
		nxt  = dec_mode;
		case (dec_mode)
			utf8d_pkg::MODE_WAIT: begin
				if (b == 8'h00)                nxt = utf8d_pkg::MODE_CLOSED;
				else if (!b[7])                done = 1'b1;
				else if (b[7:5] == 3'b110)     nxt = utf8d_pkg::MODE_NEED1;
				else if (b[7:4] == 4'b1110)    nxt = utf8d_pkg::MODE_NEED2;
				else if (b[7:3] == 5'b11110)   nxt = utf8d_pkg::MODE_NEED3;
				else if (b[7:2] == 6'b111110)  nxt = utf8d_pkg::MODE_NEED4;
				else if (b[7:1] == 7'b1111110) nxt = utf8d_pkg::MODE_NEED5;
				else                           nxt = utf8d_pkg::MODE_REFUSED;
			end
			utf8d_pkg::MODE_CLOSED, utf8d_pkg::MODE_REFUSED: nxt = utf8d_pkg::MODE_REFUSED;
			default: begin
				dec_in_multi = 1'b1;
				if (b[7:6] != 2'b10) begin
					nxt = utf8d_pkg::MODE_REFUSED;
				end else if (dec_mode == utf8d_pkg::MODE_NEED1) begin
					nxt  = utf8d_pkg::MODE_WAIT;
					done = 1'b1;
				end else begin
					nxt = utf8d_pkg::mode_t'(dec_mode - 3'd1);
				end
			end
		endcase
		if (done) begin
			dec_chars = sat_inc(dec_chars);
			if (dec_in_multi)
				dec_multi = sat_inc(dec_multi);
			dec_in_multi = 1'b0;
		end
		dec_mode    = nxt;
		r.ok        = (nxt != utf8d_pkg::MODE_REFUSED);
		r.status    = (nxt == utf8d_pkg::MODE_REFUSED) ? utf8d_pkg::STATUS_REFUSED :
		              (nxt >= utf8d_pkg::MODE_NEED1)   ? utf8d_pkg::STATUS_INSEQ   :
		                                                 utf8d_pkg::STATUS_IDLE;
		r.chars     = utf8d_pkg::field_t'(dec_chars);
		r.multi     = utf8d_pkg::field_t'(dec_multi);
		r.confident = utf8d_pkg::cmp_t'(dec_multi) > utf8d_pkg::cmp_t'(dec_thresh);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Result side: random stalls, and every result taken is checked against the oldest request.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (awaited_reports.size() == 0) begin
				$error("result taken with no request outstanding");
				fail_count++;
			end else begin
				oldest_report = awaited_reports.pop_front();
				check_field("byte_ok", oldest_report.ok, byte_ok);
				check_field("detect_status", oldest_report.status, detect_status);
				check_field("char_count", oldest_report.chars, char_count);
				check_field("multibyte_count", oldest_report.multi, multibyte_count);
				check_field("confident", oldest_report.confident, confident);
				reports_checked++;
			end
		end
		result_ready <= ($urandom_range(99) >= ready_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (result_valid && result_ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic known, input report_t want);
		report_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		do @(posedge clk); while (!(byte_valid && byte_ready));
		predicted = decode_next(b);
		awaited_reports.push_back(known ? want : predicted);
		bytes_sent++;
	endtask

	// One well-formed character: ASCII (never NUL) or a lead of two to six bytes.
	task automatic send_char();
		int         len;
		logic [7:0] lead;
		len = $urandom_range(0, 7);
		len = (len < 3) ? 1 : len - 1;
		case (len)
			1:       lead = 8'($urandom_range(1, 127));
			2:       lead = {3'b110, 5'($urandom)};
			3:       lead = {4'b1110, 4'($urandom)};
			4:       lead = {5'b11110, 3'($urandom)};
			5:       lead = {6'b111110, 2'($urandom)};
			default: lead = {7'b1111110, 1'($urandom)};
		endcase
		send_byte(lead, 1'b0, '0);
		repeat (len - 1)
			send_byte({2'b10, 6'($urandom)}, 1'b0, '0);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= THRESH_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_threshold(input utf8d_pkg::thresh_t want);
		logic [31:0] rd;
		apb_cycle(1'b0, '0, rd);
		check_field("confidence_threshold", want, rd);
	endtask

	task automatic set_threshold(input utf8d_pkg::thresh_t v);
		logic [31:0] rd;
		apb_cycle(1'b1, v, rd);
		dec_thresh = v;
		verify_threshold(v);
	endtask

	initial begin
		logic [7:0] bad;
		int         phase_start;
		dec_mode     = utf8d_pkg::MODE_WAIT;
		dec_in_multi = 1'b0;
		dec_chars    = '0;
		dec_multi    = '0;
		dec_thresh   = utf8d_pkg::THRESH_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		verify_threshold(utf8d_pkg::THRESH_RESET);

		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
		drain();

		// Pacing: free-running, sender gaps, result stalls, then both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  ready_stall_pct = 0;  set_threshold('0); end
				1: begin send_idle_pct = 66; ready_stall_pct = 0;  set_threshold('1); end
				2: begin
					send_idle_pct = 0; ready_stall_pct = 66;
					set_threshold(utf8d_pkg::thresh_t'(dec_multi) +
						utf8d_pkg::thresh_t'($urandom_range(10, 30)));
				end
				default: begin
					// Raising the threshold again should clear the flag until the count catches up.
					send_idle_pct = 30; ready_stall_pct = 30;
					set_threshold(utf8d_pkg::thresh_t'(dec_multi) +
						utf8d_pkg::thresh_t'($urandom_range(10, 30)));
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_char();
			drain();
		end

		// Refusal is permanent, so the stream is broken only once, at the very end.
		ending = ending_t'($urandom_range(0, 3));
		case (ending)
			END_STRAY_CONT: send_byte({2'b10, 6'($urandom)}, 1'b0, '0);
			END_BAD_LEAD:   send_byte(8'($urandom_range(8'hFE, 8'hFF)), 1'b0, '0);
			END_TRUNCATED: begin
				send_byte({4'b1110, 4'($urandom)}, 1'b0, '0);
				send_byte({2'b10, 6'($urandom)}, 1'b0, '0);
				do bad = 8'($urandom); while (bad[7:6] == 2'b10);
				send_byte(bad, 1'b0, '0);
			end
			default: begin
				send_byte(8'h00, 1'b0, '0);
				send_byte(8'($urandom), 1'b0, '0);
			end
		endcase
		repeat (8)
			send_byte(8'($urandom), 1'b0, '0);
		drain();
		repeat (3) @(posedge clk);

		$display("Checked %0d results for %0d bytes; %0d characters, %0d multibyte; ended by %s.",
			reports_checked, bytes_sent, dec_chars, dec_multi, ending.name());
		$display("Thresholds: reset value, zero, all ones and two raises; four pacing regimes.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8_stream_detector.sv
dv/testbench.sv
